>>> rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, register indexes and round function of the 64-bit block
// cipher core.
// ----------------------------------------------------------------------------
package gbc_pkg;

	localparam int RoundCountDefault = 32;
	localparam int WordWidth = 32;
	localparam int BlockWidth = 2 * WordWidth;
	localparam int KeyCount = 8;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 64;
	localparam int RotateLeft = 11;

	typedef logic [WordWidth-1:0] word_t;
	typedef logic [CfgIndexWidth-1:0] cfg_index_t;
	typedef logic [CfgDataWidth-1:0] cfg_data_t;

	// Register map of the configuration port.
	typedef enum logic [CfgIndexWidth-1:0] {
		REG_KEY_01 = 3'd0,
		REG_KEY_23 = 3'd1,
		REG_KEY_45 = 3'd2,
		REG_KEY_67 = 3'd3,
		REG_MODE   = 3'd4
	} cfg_reg_t;

	// Key schedule and direction as seen by every round stage.
	typedef struct packed {
		logic [KeyCount-1:0][WordWidth-1:0] key_words;
		logic                               encrypt;
	} cfg_t;

	// Substitution rows, row i serving nibble i; identity unless rebuilt.
	localparam logic [3:0] SBOX [8][16] = '{
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
		'{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
		  4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF}
	};

	// Key addition, substitution and rotation of one round.
	function automatic word_t round_f(input word_t half, input word_t key);
		word_t sum;
		word_t sub;
		sum = half + key;
		for (int i = 0; i < 8; i++) begin
			sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
		end
		return {sub[WordWidth-RotateLeft-1:0], sub[WordWidth-1:WordWidth-RotateLeft]};
	endfunction

endpackage

>>> rtl/gost_block_cipher_ecb.sv
// ----------------------------------------------------------------------------
// gost_block_cipher_ecb
// 64-bit block cipher in simple-replacement mode, one round per stage.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Contents
// s_axis    in         s_tvalid / s_tready    plaintext or ciphertext block
// m_axis    out        m_tvalid / m_tready    processed block
// cfg       in         cfg_we                 key words and direction
//
// One register stage per round; a new block may enter on every cycle while
// s_tready is high.
// The last round stage is the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and no transaction is lost or repeated.
// Reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module gost_block_cipher_ecb #(
	parameter int ROUND_COUNT = gbc_pkg::RoundCountDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// [31:0] half_low_in, [63:32] half_high_in
	input  logic [gbc_pkg::BlockWidth-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [31:0] half_low_out, [63:32] half_high_out
	output logic [gbc_pkg::BlockWidth-1:0] m_tdata,
	input  logic                     cfg_we,
	input  gbc_pkg::cfg_index_t      cfg_index,
	input  gbc_pkg::cfg_data_t       cfg_data
);
	import gbc_pkg::*;

	cfg_t                      cfg;
	logic [ROUND_COUNT:0]      vld;
	word_t                     n1 [ROUND_COUNT+1];
	word_t                     n2 [ROUND_COUNT+1];
	logic [ROUND_COUNT+1:1]    adv;

	gbc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign vld[0] = s_tvalid;
	assign n1[0]  = s_tdata[WordWidth-1:0];
	assign n2[0]  = s_tdata[BlockWidth-1:WordWidth];

	assign adv[ROUND_COUNT+1] = m_tready;

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		assign adv[r+1] = ~vld[r+1] | adv[r+2];

		gbc_round #(
			.ROUND_COUNT(ROUND_COUNT),
			.ROUND      (r)
		) u_round (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (adv[r+1]),
			.cfg          (cfg),
			.valid_in     (vld[r]),
			.half_low_in  (n1[r]),
			.half_high_in (n2[r]),
			.valid_out    (vld[r+1]),
			.half_low_out (n1[r+1]),
			.half_high_out(n2[r+1])
		);
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld[ROUND_COUNT];
	assign m_tdata  = {n2[ROUND_COUNT], n1[ROUND_COUNT]};

	// A ready sink lets every stage move.
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	// An empty output stage can always take the block before it.
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	// An accepted block lands in the first round stage.
	a_first_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld[1])
		else $error("accepted block missing from first stage");

endmodule

>>> rtl/gbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gbc_cfg_regs
// Key and direction registers, written through the configuration port.
// ----------------------------------------------------------------------------
module gbc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  gbc_pkg::cfg_index_t cfg_index,
	input  gbc_pkg::cfg_data_t  cfg_data,
	output gbc_pkg::cfg_t       cfg
);
	import gbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_01: begin
					cfg_q.key_words[0] <= cfg_data[WordWidth-1:0];
					cfg_q.key_words[1] <= cfg_data[2*WordWidth-1:WordWidth];
				end
				REG_KEY_23: begin
					cfg_q.key_words[2] <= cfg_data[WordWidth-1:0];
					cfg_q.key_words[3] <= cfg_data[2*WordWidth-1:WordWidth];
				end
				REG_KEY_45: begin
					cfg_q.key_words[4] <= cfg_data[WordWidth-1:0];
					cfg_q.key_words[5] <= cfg_data[2*WordWidth-1:WordWidth];
				end
				REG_KEY_67: begin
					cfg_q.key_words[6] <= cfg_data[WordWidth-1:0];
					cfg_q.key_words[7] <= cfg_data[2*WordWidth-1:WordWidth];
				end
				REG_MODE: begin
					cfg_q.encrypt <= cfg_data[0];
				end
				default: begin
					// Indexes beyond the map are ignored.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/gbc_round.sv
// ----------------------------------------------------------------------------
// gbc_round
// One Feistel round as a pipeline stage with its own valid bit.
// ----------------------------------------------------------------------------
module gbc_round #(
	parameter int ROUND_COUNT = gbc_pkg::RoundCountDefault,
	parameter int ROUND       = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  gbc_pkg::cfg_t cfg,
	input  logic          valid_in,
	input  gbc_pkg::word_t half_low_in,
	input  gbc_pkg::word_t half_high_in,
	output logic          valid_out,
	output gbc_pkg::word_t half_low_out,
	output gbc_pkg::word_t half_high_out
);
	import gbc_pkg::*;

	localparam logic [2:0] KeyFwd = 3'(ROUND % KeyCount);
	localparam logic [2:0] KeyRev = 3'(KeyCount - 1 - (ROUND % KeyCount));
	localparam bit         IsLast = (ROUND == ROUND_COUNT - 1);
	localparam bit         FwdEnc = (ROUND < ROUND_COUNT - KeyCount);
	localparam bit         FwdDec = (ROUND < KeyCount);

	logic       fwd;
	logic [2:0] key_sel;
	word_t      mixed;

	logic  valid_s;
	word_t half_low_s;
	word_t half_high_s;

	// Rounds run forward through the key words first, then in reverse.
	assign fwd     = cfg.encrypt ? FwdEnc : FwdDec;
	assign key_sel = fwd ? KeyFwd : KeyRev;
	assign mixed   = half_high_in ^ round_f(half_low_in, cfg.key_words[key_sel]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (advance) begin
			valid_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_in) begin
			if (IsLast) begin
				half_low_s  <= half_low_in;
				half_high_s <= mixed;
			end else begin
				half_low_s  <= mixed;
				half_high_s <= half_low_in;
			end
		end
	end

	assign valid_out     = valid_s;
	assign half_low_out  = half_low_s;
	assign half_high_out = half_high_s;

endmodule
